### hdl/ipkd_pkg.sv
// Package for the IR pulse interval key decoder.
// Holds the register map, reset values, result kinds and window hit struct.
// No dependencies.
`timescale 1ns / 1ps

package ipkd_pkg;

  localparam int unsigned IntervalW = 16;
  localparam int unsigned KeyW      = 32;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned DataW     = 32;

  typedef enum logic [2:0] {
    REG_START  = 3'd0,
    REG_REPEAT = 3'd1,
    REG_ZERO   = 3'd2,
    REG_ONE    = 3'd3,
    REG_GUARD  = 3'd4
  } reg_idx_e;

  localparam logic [IntervalW-1:0] StartReset  = 16'd13500;
  localparam logic [IntervalW-1:0] RepeatReset = 16'd11250;
  localparam logic [IntervalW-1:0] ZeroReset   = 16'd1125;
  localparam logic [IntervalW-1:0] OneReset    = 16'd2250;
  localparam logic [IntervalW-1:0] GuardReset  = 16'd300;

  typedef enum logic [1:0] {
    KIND_NEW    = 2'd0,
    KIND_REPEAT = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [IntervalW-1:0] start_nom;
    logic [IntervalW-1:0] rpt_nom;
    logic [IntervalW-1:0] zero_nom;
    logic [IntervalW-1:0] one_nom;
    logic [IntervalW-1:0] guard;
  } ipkd_cfg_t;

  typedef struct packed {
    logic start;
    logic rpt;
    logic zero;
    logic one;
  } ipkd_hits_t;

endpackage

### hdl/ipkd_classify.sv
// Window classifier: tests one interval against the start, repeat, zero
// and one windows with strict bounds, no wrap. Depends on ipkd_pkg.
`timescale 1ns / 1ps

module ipkd_classify import ipkd_pkg::*; (
  input  logic [IntervalW-1:0] interval_i,
  input  ipkd_cfg_t            cfg_i,
  output ipkd_hits_t           hits_o
);

  function automatic logic in_win(logic [IntervalW-1:0] x, logic [IntervalW-1:0] nom,
                                  logic [IntervalW-1:0] g);
    logic [IntervalW:0] lo_sum;
    logic [IntervalW:0] hi_sum;
    lo_sum = {1'b0, x} + {1'b0, g};
    hi_sum = {1'b0, nom} + {1'b0, g};
    return (lo_sum > {1'b0, nom}) && ({1'b0, x} < hi_sum);
  endfunction

  always_comb begin
    hits_o.start = in_win(interval_i, cfg_i.start_nom, cfg_i.guard);
    hits_o.rpt   = in_win(interval_i, cfg_i.rpt_nom, cfg_i.guard);
    hits_o.zero  = in_win(interval_i, cfg_i.zero_nom, cfg_i.guard);
    hits_o.one   = in_win(interval_i, cfg_i.one_nom, cfg_i.guard);
  end

endmodule

### hdl/ir_pulse_interval_key_decoder.sv
// Top level of the IR pulse interval key decoder: APB register file,
// input register, frame state and result register. Depends on ipkd_pkg
// and ipkd_classify.
//
// One interval beat is taken per cycle while in_stall_o is low. A beat is
// held in the input register, classified there and applied to the frame
// state when it leaves that register; its result, if any, is loaded into
// the result register at the same clock edge. One beat per cycle is
// sustained while the result register is not stalled. The rate is set by
// the single compare-and-shift stage between the input register and the
// result register. Intervals that produce no result never wait on a stalled result register.
`timescale 1ns / 1ps

module ir_pulse_interval_key_decoder import ipkd_pkg::*; #(
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrW-1:0]     paddr,
  input  logic [DataW-1:0]     pwdata,
  output logic [DataW-1:0]     prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [IntervalW-1:0] interval_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [KeyW-1:0]      key_code_o,
  output logic [1:0]           kind_o
);

  localparam int unsigned CntW = $clog2(KEY_BITS);
  localparam logic [CntW-1:0] CntLast = CntW'(KEY_BITS - 1);

  ipkd_cfg_t cfg_q;
  logic      cfg_we;
  reg_idx_e  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_nom <= StartReset;
      cfg_q.rpt_nom   <= RepeatReset;
      cfg_q.zero_nom  <= ZeroReset;
      cfg_q.one_nom   <= OneReset;
      cfg_q.guard     <= GuardReset;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_START:  cfg_q.start_nom <= pwdata[IntervalW-1:0];
        REG_REPEAT: cfg_q.rpt_nom   <= pwdata[IntervalW-1:0];
        REG_ZERO:   cfg_q.zero_nom  <= pwdata[IntervalW-1:0];
        REG_ONE:    cfg_q.one_nom   <= pwdata[IntervalW-1:0];
        REG_GUARD:  cfg_q.guard     <= pwdata[IntervalW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_START:  prdata = DataW'(cfg_q.start_nom);
      REG_REPEAT: prdata = DataW'(cfg_q.rpt_nom);
      REG_ZERO:   prdata = DataW'(cfg_q.zero_nom);
      REG_ONE:    prdata = DataW'(cfg_q.one_nom);
      REG_GUARD:  prdata = DataW'(cfg_q.guard);
      default:    prdata = '0;
    endcase
  end

  // input register
  logic                 s1_valid_q, s1_valid_d;
  logic [IntervalW-1:0] s1_interval_q;
  logic                 in_accept;
  logic                 s1_go;

  assign in_stall_o = s1_valid_q & ~s1_go;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_interval_q <= interval_i;
    end
  end

  ipkd_hits_t hits;

  ipkd_classify u_classify (
    .interval_i (s1_interval_q),
    .cfg_i      (cfg_q),
    .hits_o     (hits)
  );

  // frame state
  logic              in_frame_q, in_frame_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [KeyW-1:0]   shift_q, shift_d;
  logic [KeyW-1:0]   last_key_q, last_key_d;
  logic              res_valid;
  logic [KeyW-1:0]   res_key;
  kind_e             res_kind;
  logic [KeyW-1:0]   shifted;

  assign shifted = {shift_q[KeyW-2:0], ~hits.zero};

  always_comb begin
    in_frame_d = in_frame_q;
    cnt_d      = cnt_q;
    shift_d    = shift_q;
    last_key_d = last_key_q;
    res_valid  = 1'b0;
    res_key    = last_key_q;
    res_kind   = KIND_REPEAT;
    if (!in_frame_q) begin
      if (hits.start) begin
        in_frame_d = 1'b1;
        cnt_d      = '0;
        shift_d    = '0;
      end else if (hits.rpt) begin
        res_valid = 1'b1;
      end
    end else if (hits.zero || hits.one) begin
      shift_d = shifted;
      if (cnt_q == CntLast) begin
        in_frame_d = 1'b0;
        cnt_d      = '0;
        last_key_d = shifted;
        res_valid  = 1'b1;
        res_key    = shifted;
        res_kind   = KIND_NEW;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
    end else begin
      in_frame_d = 1'b0;
      cnt_d      = '0;
      shift_d    = '0;
      last_key_d = '0;
      res_valid  = 1'b1;
      res_key    = '0;
      res_kind   = KIND_ERROR;
    end
  end

  // result register
  logic            out_valid_q, out_valid_d;
  logic [KeyW-1:0] out_key_q;
  kind_e           out_kind_q;
  logic            out_load;

  assign out_load = ~out_valid_q | ~out_stall_i;
  assign s1_go    = s1_valid_q & (~res_valid | out_load);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = s1_go & res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      cnt_q       <= '0;
      shift_q     <= '0;
      last_key_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (s1_go) begin
        in_frame_q <= in_frame_d;
        cnt_q      <= cnt_d;
        shift_q    <= shift_d;
        last_key_q <= last_key_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && res_valid) begin
      out_key_q  <= res_key;
      out_kind_q <= res_kind;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_code_o  = out_key_q;
  assign kind_o      = out_kind_q;

endmodule

### sim/ir_pulse_interval_key_decoder_tb.sv
// Self-checking testbench for the IR pulse interval key decoder: directed
// window edges and overlaps, then random NEC-style frames, under four idle mixes.
// Depends on ipkd_pkg and the ir_pulse_interval_key_decoder RTL.
`timescale 1ns / 1ps

module ir_pulse_interval_key_decoder_tb;
  import ipkd_pkg::*;

  localparam int unsigned KeyBits     = 32;
  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned RandomItems = 1100;
  localparam int unsigned PhaseItems  = 140;

  typedef struct packed {
    logic [KeyW-1:0] key;
    kind_e           kind;
  } key_beat_t;

  class key_scoreboard;
    ipkd_cfg_t       cfg;
    logic            in_frame;
    logic [5:0]      bits_taken;
    logic [KeyW-1:0] shift_word;
    logic [KeyW-1:0] last_key;
    key_beat_t       pending_keys[$];
    int              errors;

    function new();
      cfg        = '{StartReset, RepeatReset, ZeroReset, OneReset, GuardReset};
      in_frame   = 1'b0;
      bits_taken = '0;
      shift_word = '0;
      last_key   = '0;
      errors     = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [IntervalW-1:0] v);
      case (idx)
        REG_START:  cfg.start_nom = v;
        REG_REPEAT: cfg.rpt_nom   = v;
        REG_ZERO:   cfg.zero_nom  = v;
        REG_ONE:    cfg.one_nom   = v;
        REG_GUARD:  cfg.guard     = v;
        default: ;
      endcase
    endfunction

    function bit hit(logic [IntervalW-1:0] x, logic [IntervalW-1:0] nom);
      logic [IntervalW:0] xs;
      logic [IntervalW:0] ns;
      logic [IntervalW:0] gs;
      xs = {1'b0, x};
      ns = {1'b0, nom};
      gs = {1'b0, cfg.guard};
      return (xs + gs > ns) && (xs < ns + gs);
    endfunction

    function void note_interval(logic [IntervalW-1:0] x);
      logic bit_val;
      if (!in_frame) begin
        if (hit(x, cfg.start_nom)) begin
          in_frame   = 1'b1;
          bits_taken = '0;
          shift_word = '0;
        end else if (hit(x, cfg.rpt_nom)) begin
          pending_keys.push_back('{last_key, KIND_REPEAT});
        end
        return;
      end
      if (hit(x, cfg.zero_nom)) begin
        bit_val = 1'b0;
      end else if (hit(x, cfg.one_nom)) begin
        bit_val = 1'b1;
      end else begin
        in_frame   = 1'b0;
        bits_taken = '0;
        shift_word = '0;
        last_key   = '0;
        pending_keys.push_back('{'0, KIND_ERROR});
        return;
      end
      shift_word = {shift_word[KeyW-2:0], bit_val};
      bits_taken = bits_taken + 6'd1;
      if (bits_taken >= KeyBits || bits_taken == 6'd0) begin
        in_frame   = 1'b0;
        bits_taken = '0;
        last_key   = shift_word;
        pending_keys.push_back('{shift_word, KIND_NEW});
      end
    endfunction

    function void report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    function void check_key(logic [KeyW-1:0] key, logic [1:0] kind);
      key_beat_t want;
      if (pending_keys.size() == 0) begin
        report($sformatf("unexpected result key %h kind %0d", key, kind));
        return;
      end
      want = pending_keys.pop_front();
      if (key !== want.key) report($sformatf("key %h, want %h", key, want.key));
      if (kind !== want.kind) report($sformatf("kind %0d, want %0d", kind, want.kind));
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [AddrW-1:0]     paddr       = '0;
  logic [DataW-1:0]     pwdata      = '0;
  logic [DataW-1:0]     prdata;
  logic                 pready;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [IntervalW-1:0] interval_i  = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [KeyW-1:0]      key_code_o;
  logic [1:0]           kind_o;

  key_scoreboard sb = new();
  int            idle_pct    = 0;
  int            stall_pct   = 0;
  int            items       = 0;
  int unsigned   idle_cycles = 0;

  ir_pulse_interval_key_decoder #(
    .KEY_BITS(KeyBits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .interval_i (interval_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .key_code_o (key_code_o),
    .kind_o     (kind_o)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_key(key_code_o, kind_o);
      if (in_valid_i && !in_stall_o) sb.note_interval(interval_i);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o) || (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("ir_pulse_interval_key_decoder test failed");
          $finish;
        end
      end
    end
  end

  task automatic push_interval(input logic [IntervalW-1:0] v);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    interval_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items++;
    @(negedge clk_i);
  endtask

  // hold off until every expected beat is out and the pipeline is empty
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_keys.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [IntervalW-1:0] v);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(DataW-IntervalW){1'b0}}, v};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic load_config(input logic [IntervalW-1:0] st, input logic [IntervalW-1:0] rp,
                             input logic [IntervalW-1:0] zr, input logic [IntervalW-1:0] on,
                             input logic [IntervalW-1:0] gd);
    write_reg(REG_START, st);
    write_reg(REG_REPEAT, rp);
    write_reg(REG_ZERO, zr);
    write_reg(REG_ONE, on);
    write_reg(REG_GUARD, gd);
  endtask

  function automatic logic [IntervalW-1:0] pick_in(logic [IntervalW-1:0] nom);
    int lo;
    int hi;
    lo = int'(nom) - int'(sb.cfg.guard) + 1;
    hi = int'(nom) + int'(sb.cfg.guard) - 1;
    if (lo < 0) lo = 0;
    if (hi > 65535) hi = 65535;
    if (lo > hi) return nom;
    return IntervalW'($urandom_range(hi, lo));
  endfunction

  task automatic send_frame(input logic [KeyW-1:0] key);
    push_interval(pick_in(sb.cfg.start_nom));
    for (int i = KeyBits - 1; i >= 0; i--) begin
      push_interval(pick_in(key[i] ? sb.cfg.one_nom : sb.cfg.zero_nom));
    end
  endtask

  task automatic broken_frame();
    int n;
    n = $urandom_range(KeyBits - 1);
    push_interval(pick_in(sb.cfg.start_nom));
    repeat (n) push_interval(pick_in($urandom_range(1) ? sb.cfg.one_nom : sb.cfg.zero_nom));
    push_interval(IntervalW'($urandom_range(65535)));
  endtask

  initial begin
    int base;
    int phase_end;
    int r;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_interval(16'd0);
    push_interval(16'd65535);
    push_interval(16'd11250);
    push_interval(16'd13500);
    push_interval(16'd1125);
    push_interval(16'd13500);
    push_interval(16'd10951);
    push_interval(16'd10950);
    send_frame(32'hA5C3_0F96);
    push_interval(16'd11549);
    push_interval(16'd13799);
    push_interval(16'd2250);
    push_interval(16'd2549);
    push_interval(16'd826);
    push_interval(16'd1424);
    push_interval(16'd1425);

    write_reg(REG_REPEAT, 16'd13500);
    push_interval(16'd13500);
    push_interval(16'd40000);
    write_reg(REG_REPEAT, RepeatReset);
    write_reg(REG_ONE, ZeroReset);
    push_interval(16'd13500);
    push_interval(16'd1125);
    push_interval(16'd5000);
    write_reg(REG_ONE, OneReset);
    write_reg(REG_ZERO, 16'd100);
    push_interval(16'd13500);
    push_interval(16'd0);
    push_interval(16'd65535);
    write_reg(REG_GUARD, 16'd0);
    push_interval(16'd13500);
    push_interval(16'd11250);

    base = items;
    for (int phase = 0; items - base < RandomItems; phase++) begin
      case (phase % 6)
        0: load_config(StartReset, RepeatReset, ZeroReset, OneReset, GuardReset);
        1: load_config(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
        2: load_config(IntervalW'($urandom_range(65535)), IntervalW'($urandom_range(65535)),
                       IntervalW'($urandom_range(8000)), IntervalW'($urandom_range(16000)), 16'd1);
        3: load_config(IntervalW'($urandom_range(65535)), IntervalW'($urandom_range(65535)),
                       16'd100, 16'd400, 16'd300);
        default: begin
          write_reg(REG_START, IntervalW'($urandom_range(65535)));
          write_reg(REG_REPEAT, $urandom_range(1) ? sb.cfg.start_nom
                                                  : IntervalW'($urandom_range(65535)));
          write_reg(REG_ZERO, IntervalW'($urandom_range(8000)));
          write_reg(REG_ONE, $urandom_range(3) == 0 ? sb.cfg.zero_nom
                                                    : IntervalW'($urandom_range(16000)));
          write_reg(REG_GUARD, $urandom_range(3) == 0 ? IntervalW'($urandom_range(65535))
                                                      : IntervalW'($urandom_range(2000, 1)));
        end
      endcase
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      phase_end = items + PhaseItems;
      while (items < phase_end) begin
        r = $urandom_range(99);
        if (r < 60) send_frame($urandom);
        else if (r < 75) push_interval(pick_in(sb.cfg.rpt_nom));
        else if (r < 85) broken_frame();
        else push_interval(IntervalW'($urandom_range(65535)));
        if ($urandom_range(199) == 0) drain();
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending_keys.size() == 0) begin
      $display("ir_pulse_interval_key_decoder test passed");
    end else begin
      $display("ir_pulse_interval_key_decoder test failed");
    end
    $finish;
  end

endmodule
